FILE: rtl/core/assert_macros.svh
// assertion macros shared by the palette allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_PROP(label, clk, rst, !(expr), msg)

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: rtl/core/cpa_pkg.sv
// package with widths, codes and defaults of the palette allocator
package cpa_pkg;

   localparam int CMD_W         = 2;
   localparam int RGB_W         = 24;
   localparam int SLOT_W        = 4;
   localparam int PIDX_W        = 4;
   localparam int STATUS_W      = 2;
   localparam int DAC_W         = 6;
   localparam int DEFAULT_ENTRIES = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_SET    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT  = 2'd0,
      ST_NEW  = 2'd1,
      ST_FULL = 2'd2,
      ST_DONE = 2'd3
   } status_type;

endpackage

FILE: rtl/core/cpa_if.sv
// request and response channel interfaces of the palette allocator
interface cpa_req_if
   import cpa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [RGB_W-1:0]    color_rgb;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, command, color_rgb, slot_index, input ready);
   modport sink   (input valid, command, color_rgb, slot_index, output ready);
endinterface

interface cpa_rsp_if
   import cpa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [PIDX_W-1:0]   palette_index;
   logic [STATUS_W-1:0] status;
   logic                dac_write;
   logic [DAC_W-1:0]    dac_red;
   logic [DAC_W-1:0]    dac_green;
   logic [DAC_W-1:0]    dac_blue;

   modport source (output valid, palette_index, status, dac_write, dac_red, dac_green,
                   dac_blue, input ready);
   modport sink   (input valid, palette_index, status, dac_write, dac_red, dac_green,
                   dac_blue, output ready);
endinterface

FILE: rtl/core/color_palette_allocator.sv
// color_palette_allocator: palette table with lookup, allocate on miss, set and clear
//
// req_chan takes one command word per handshake: clear, lookup or set. every
// command word gives exactly one response word on rsp_chan, in order.
// a lookup returns the lowest valid slot holding the color (status hit); on a
// miss the slot at the allocation pointer is filled, the pointer advances and
// a dac write with 6-bit components is reported (status new). with no free
// slot the response carries status full and nothing changes. set writes a
// chosen slot in range and reports the dac write; clear drops all valid bits
// and the allocation pointer. the accepting edge fills the input register and
// a later advance edge the response register. throughput: one word per cycle
// unless rsp_chan stalls; the whole lookup is one pass of ENTRIES
// parallel comparators and a priority encoder between the two registers.
// reset (synchronous) empties both registers, clears every valid bit and the
// allocation pointer; slot colors are left as they are.
// when rsp_chan stalls, the response register holds its word, the input
// register keeps at most one more word and req_chan.ready drops after that.
module color_palette_allocator
   import cpa_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  logic       clock,
   input  logic       reset,
   cpa_req_if.sink    req_chan,
   cpa_rsp_if.source  rsp_chan
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // input register
   logic              in_valid_ff;
   logic [CMD_W-1:0]  in_cmd_ff;
   logic [RGB_W-1:0]  in_rgb_ff;
   logic [SLOT_W-1:0] in_slot_ff;

   // response register
   logic                out_valid_ff;
   logic [PIDX_W-1:0]   out_index_ff, out_index_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_dac_ff, out_dac_in;
   logic [DAC_W-1:0]    out_red_ff, out_red_in;
   logic [DAC_W-1:0]    out_green_ff, out_green_in;
   logic [DAC_W-1:0]    out_blue_ff, out_blue_in;

   // palette state
   logic [RGB_W-1:0]   slot_color_ff [ENTRIES];
   logic [ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]   next_free_ff, next_free_in;

   logic               advance;
   logic [ENTRIES-1:0] hit_vec;
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic               table_full;
   logic               set_in_range;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   alloc_addr;
   logic [IDX_W-1:0]   set_addr;

   // the input stage moves on when the response register is free or drains
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff  <= req_chan.command;
         in_rgb_ff  <= req_chan.color_rgb;
         in_slot_ff <= req_chan.slot_index;
      end
   end

   // cam compare, one comparator per slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = slot_valid_ff[i] && (slot_color_ff[i] == in_rgb_ff);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any      = |hit_vec;
   assign table_full   = (next_free_ff == CNT_W'(ENTRIES));
   assign alloc_addr   = next_free_ff[IDX_W-1:0];
   // slot numbers past the table are ignored by set
   assign set_in_range = (32'(in_slot_ff) < ENTRIES);
   assign set_addr     = IDX_W'(in_slot_ff);

   // command decode: response word and table update
   always_comb begin
      out_index_in  = '0;
      out_status_in = ST_DONE;
      out_dac_in    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = alloc_addr;
      slot_valid_in = slot_valid_ff;
      next_free_in  = next_free_ff;
      case (in_cmd_ff)
         CMD_CLEAR: begin
            slot_valid_in = '0;
            next_free_in  = '0;
         end
         CMD_LOOKUP: begin
            if (hit_any) begin
               out_index_in  = PIDX_W'(hit_idx);
               out_status_in = ST_HIT;
            end else if (table_full) begin
               out_status_in = ST_FULL;
            end else begin
               out_index_in  = PIDX_W'(alloc_addr);
               out_status_in = ST_NEW;
               out_dac_in    = 1'b1;
               wr_en         = 1'b1;
               next_free_in  = next_free_ff + 1'b1;
            end
         end
         CMD_SET: begin
            if (set_in_range) begin
               out_index_in = PIDX_W'(set_addr);
               out_dac_in   = 1'b1;
               wr_en        = 1'b1;
               wr_addr      = set_addr;
            end
         end
         default: begin
         end
      endcase
      if (wr_en) begin
         slot_valid_in[wr_addr] = 1'b1;
      end
   end

   // dac takes the top six bits of each component, zero when not written
   assign out_red_in   = out_dac_in ? in_rgb_ff[23:18] : '0;
   assign out_green_in = out_dac_in ? in_rgb_ff[15:10] : '0;
   assign out_blue_in  = out_dac_in ? in_rgb_ff[7:2]   : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         next_free_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            slot_valid_ff <= slot_valid_in;
            next_free_ff  <= next_free_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // color store, one write port
   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         slot_color_ff[wr_addr] <= in_rgb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_index_ff  <= out_index_in;
         out_status_ff <= out_status_in;
         out_dac_ff    <= out_dac_in;
         out_red_ff    <= out_red_in;
         out_green_ff  <= out_green_in;
         out_blue_ff   <= out_blue_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.palette_index = out_index_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.dac_write     = out_dac_ff;
   assign rsp_chan.dac_red       = out_red_ff;
   assign rsp_chan.dac_green     = out_green_ff;
   assign rsp_chan.dac_blue      = out_blue_ff;

   // allocation pointer never runs past the table
   `ASSERT_NEVER(a_next_free_range, clock, reset,
      next_free_ff > CNT_W'(ENTRIES), "allocation pointer beyond table")

   // a clear leaves an empty table behind
   `ASSERT_PROP(a_clear_empties, clock, reset,
      (advance && in_cmd_ff == CMD_CLEAR) |=> (slot_valid_ff == '0 && next_free_ff == '0),
      "clear did not empty the table")

   // an allocation moves the pointer by exactly one
   `ASSERT_PROP(a_alloc_step, clock, reset,
      (advance && in_cmd_ff == CMD_LOOKUP && !hit_any && !table_full)
         |=> (next_free_ff == $past(next_free_ff) + 1'b1),
      "allocation pointer did not advance by one")

   // a full response is only shown while the table is really full
   `ASSERT_PROP(a_full_consistent, clock, reset,
      (out_valid_ff && out_status_ff == ST_FULL) |-> table_full,
      "full status without a full table")

endmodule
